### design/spq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 8;
    localparam int PRI_W    = 3;
    localparam int OCC_W    = 5;
    localparam int STAT_W   = 2;

    typedef enum logic [0:0] {
        SPQ_OP_PUSH = 1'b0,
        SPQ_OP_POP  = 1'b1
    } spq_op_t;

    typedef enum logic [STAT_W-1:0] {
        SPQ_ST_OK    = 2'd0,
        SPQ_ST_FULL  = 2'd1,
        SPQ_ST_EMPTY = 2'd2
    } spq_status_t;

    typedef struct packed {
        spq_op_t           opcode;
        logic [VAL_W-1:0]  item_value;
        logic [PRI_W-1:0]  item_priority;
    } spq_in_t;

    typedef struct packed {
        logic [VAL_W-1:0]  popped_value;
        logic [PRI_W-1:0]  popped_priority;
        spq_status_t       status;
        logic [OCC_W-1:0]  occupancy;
    } spq_out_t;

    // One stored entry of the queue.
    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [PRI_W-1:0]  pri;
    } spq_entry_t;

    // Command broadcast to every cell; push and pop are already qualified
    // against full and empty.
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [VAL_W-1:0]  value;
        logic [PRI_W-1:0]  pri;
    } spq_cmd_t;

endpackage

### design/sorted_priority_queue.sv
`timescale 1ns / 1ps
// Top level of the sorted priority queue built from a chain of cells.
//
//  Channel  Direction  Handshake          Payload
//  s_       in         s_valid / s_ready  spq_in_t  (opcode, value, priority)
//  m_       out        m_valid / m_ready  spq_out_t (value, priority, status, occupancy)
//
// Every transfer on the input side is executed in the cycle it is accepted:
// all cells update in parallel, so one push or pop is taken per clock unless
// m_ready stalls; the result is registered in the cycle after its transfer.
// The input side is ready whenever the output register is empty or is being
// drained in the same cycle, so a stall on m_ready holds back at most one item.
// Reset (aresetn low, synchronous) empties the queue by clearing the occupied
// flags; stored entry data is not cleared.
module sorted_priority_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  spq_pkg::spq_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output spq_pkg::spq_out_t  m_data
);

    logic                            accept;
    logic                            full;
    logic                            empty;
    spq_pkg::spq_cmd_t               cmd;
    logic [spq_pkg::CAPACITY-1:0]    valid_vec;
    logic [spq_pkg::CAPACITY-1:0]    go_vec;
    spq_pkg::spq_entry_t             cell_entry [spq_pkg::CAPACITY];
    spq_pkg::spq_entry_t             cell_tail  [spq_pkg::CAPACITY];
    spq_pkg::spq_entry_t             tail;

    logic [spq_pkg::CNT_W-1:0]       count_reg;
    logic [spq_pkg::CNT_W-1:0]       count_next;
    logic                            m_valid_reg;
    logic                            m_valid_next;
    spq_pkg::spq_out_t               m_data_reg;
    spq_pkg::spq_out_t               m_data_next;

    // The output register is the only buffer between the two sides.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Occupied flags form a thermometer from the head, so the last and first
    // cells tell full and empty directly.
    assign full  = valid_vec[spq_pkg::CAPACITY-1];
    assign empty = !valid_vec[0];

    always_comb begin
        cmd.push  = accept && (s_data.opcode == spq_pkg::SPQ_OP_PUSH) && !full;
        cmd.pop   = accept && (s_data.opcode == spq_pkg::SPQ_OP_POP) && !empty;
        cmd.value = s_data.item_value;
        cmd.pri   = s_data.item_priority;
    end

    for (genvar i = 0; i < spq_pkg::CAPACITY; i++) begin : g_cell
        logic                prev_go;
        logic                prev_valid;
        spq_pkg::spq_entry_t prev_entry;
        logic                next_valid;

        if (i == 0) begin : g_head
            assign prev_go    = 1'b1;
            assign prev_valid = 1'b1;
            assign prev_entry = '0;
        end else begin : g_body
            assign prev_go    = go_vec[i-1];
            assign prev_valid = valid_vec[i-1];
            assign prev_entry = cell_entry[i-1];
        end

        if (i == spq_pkg::CAPACITY - 1) begin : g_last
            assign next_valid = 1'b0;
        end else begin : g_inner
            assign next_valid = valid_vec[i+1];
        end

        spq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .prev_go    (prev_go),
            .prev_valid (prev_valid),
            .prev_entry (prev_entry),
            .next_valid (next_valid),
            .go         (go_vec[i]),
            .valid      (valid_vec[i]),
            .entry      (cell_entry[i]),
            .tail_entry (cell_tail[i])
        );
    end

    // Only the tail cell drives a nonzero tail entry, so an OR picks it.
    always_comb begin
        tail = '0;
        for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
            tail = tail | cell_tail[i];
        end
    end

    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next                = 1'b1;
            m_data_next.popped_value    = '0;
            m_data_next.popped_priority = '0;
            m_data_next.status          = spq_pkg::SPQ_ST_OK;
            if (s_data.opcode == spq_pkg::SPQ_OP_POP) begin
                if (empty) begin
                    m_data_next.status = spq_pkg::SPQ_ST_EMPTY;
                end else begin
                    m_data_next.popped_value    = tail.value;
                    m_data_next.popped_priority = tail.pri;
                    count_next = count_reg - spq_pkg::CNT_W'(1);
                end
            end else begin
                if (full) begin
                    m_data_next.status = spq_pkg::SPQ_ST_FULL;
                end else begin
                    count_next = count_reg + spq_pkg::CNT_W'(1);
                end
            end
            // Occupancy reports the count modulo 32.
            m_data_next.occupancy = spq_pkg::OCC_W'(32'(count_next));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // The count register and the occupied flags describe the same fill level.
    a_count_matches_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == 32'(count_reg))
        else $error("entry count disagrees with occupied flags");

    // Occupied cells form one unbroken run starting at the head.
    a_flags_thermometer: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(valid_vec ^ (valid_vec >> 1)))
        else $error("occupied flags are not contiguous from the head");

    // A push that fits grows the queue by exactly one entry.
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |=> count_reg == $past(count_reg) + spq_pkg::CNT_W'(1))
        else $error("push did not add one entry");

    // A pop from an empty queue reports zero occupancy.
    a_empty_pop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status == spq_pkg::SPQ_ST_EMPTY)
            |-> m_data_reg.occupancy == '0)
        else $error("empty pop reported nonzero occupancy");
`endif

endmodule

### design/spq_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted chain: holds an entry and its occupied flag.
module spq_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  spq_pkg::spq_cmd_t    cmd,
    input  logic                 prev_go,
    input  logic                 prev_valid,
    input  spq_pkg::spq_entry_t  prev_entry,
    input  logic                 next_valid,
    output logic                 go,
    output logic                 valid,
    output spq_pkg::spq_entry_t  entry,
    output spq_pkg::spq_entry_t  tail_entry
);

    logic                valid_reg;
    logic                valid_next;
    spq_pkg::spq_entry_t entry_reg;
    spq_pkg::spq_entry_t entry_next;
    spq_pkg::spq_entry_t new_entry;

    // The new item passes this slot when the slot holds a strictly higher
    // priority value; the chain is sorted, so these slots form a prefix.
    assign go = valid_reg && (cmd.pri < entry_reg.pri);

    always_comb begin
        new_entry.value = cmd.value;
        new_entry.pri   = cmd.pri;
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (cmd.push) begin
            valid_next = prev_valid;
            if (!go) begin
                entry_next = prev_go ? new_entry : prev_entry;
            end
        end else if (cmd.pop) begin
            valid_next = next_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign valid      = valid_reg;
    assign entry      = entry_reg;
    assign tail_entry = (valid_reg && !next_valid) ? entry_reg : '0;

endmodule
